>>> rtl/core/tat_pkg.sv
// ----------------------------------------------------------------------------
// tat_pkg
// Shared types and constants for the accelerometer tilt block.
// ----------------------------------------------------------------------------
package tat_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int IDX_W        = 4;
  localparam int XW           = 30;
  localparam int AW           = 25;
  localparam int DW_IN        = 17;
  localparam logic [15:0] INV_GAIN = 16'd39797;
  localparam logic signed [AW-1:0] ANG_90  = 25'sd5898240;
  localparam logic signed [AW-1:0] ANG_GRD = 25'sd128;

  localparam logic [1:0] REG_BIAS_X = 2'd0;
  localparam logic [1:0] REG_BIAS_Y = 2'd1;
  localparam logic [1:0] REG_BIAS_Z = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CSTART,
    ST_RUN,
    ST_POST,
    ST_WRD,
    ST_SUM,
    ST_DSTART,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic             load;
    logic             cord_load;
    logic             cord_step;
    logic [IDX_W-1:0] idx;
    logic [1:0]       pass;
    logic             mul;
    logic             fin;
    logic             win_rd;
    logic             win_upd;
    logic             div_start;
    logic             div_step;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

  function automatic logic signed [AW-1:0] atan_deg(input logic [IDX_W-1:0] i);
    logic signed [AW-1:0] v;
    case (i)
      4'd0:    v = 25'sd2949120;
      4'd1:    v = 25'sd1740967;
      4'd2:    v = 25'sd919879;
      4'd3:    v = 25'sd466945;
      4'd4:    v = 25'sd234379;
      4'd5:    v = 25'sd117304;
      4'd6:    v = 25'sd58666;
      4'd7:    v = 25'sd29335;
      4'd8:    v = 25'sd14668;
      4'd9:    v = 25'sd7334;
      4'd10:   v = 25'sd3667;
      4'd11:   v = 25'sd1833;
      4'd12:   v = 25'sd917;
      4'd13:   v = 25'sd458;
      4'd14:   v = 25'sd229;
      default: v = 25'sd115;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/tat_cordic.sv
// ----------------------------------------------------------------------------
// tat_cordic
// Shared CORDIC vectoring unit, one micro-rotation per cycle while step is high.
// ----------------------------------------------------------------------------
module tat_cordic (
  input  logic                             clk,
  input  logic                             load,
  input  logic                             step,
  input  logic [tat_pkg::IDX_W-1:0]        idx,
  input  logic signed [tat_pkg::XW-1:0]    x0,
  input  logic signed [tat_pkg::XW-1:0]    y0,
  output logic signed [tat_pkg::XW-1:0]    x_out,
  output logic signed [tat_pkg::AW-1:0]    ang_out
);

  logic signed [tat_pkg::XW-1:0] x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic signed [tat_pkg::AW-1:0] a_r, a_nxt;

  always_comb begin
    xs = x_r >>> idx;
    ys = y_r >>> idx;
    if (y_r > 0) begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      a_nxt = a_r + tat_pkg::atan_deg(idx);
    end else begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      a_nxt = a_r - tat_pkg::atan_deg(idx);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_r <= x0;
      y_r <= y0;
      a_r <= '0;
    end else if (step) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      a_r <= a_nxt;
    end
  end

  assign x_out   = x_r;
  assign ang_out = a_r;

endmodule

>>> rtl/core/tat_dp.sv
// ----------------------------------------------------------------------------
// tat_dp
// Datapath: bias, CORDIC passes, gain removal, angle finish, window and divide.
// ----------------------------------------------------------------------------
module tat_dp #(
  parameter int AVG_WINDOW = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tat_pkg::cmd_t        cmd,
  output tat_pkg::status_t     status,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic signed [15:0]   in_accel_x,
  input  logic signed [15:0]   in_accel_y,
  input  logic signed [15:0]   in_accel_z,
  output logic [6:0]           out_roll_now,
  output logic [8:0]           out_pitch_now,
  output logic [6:0]           out_roll_avg,
  output logic [8:0]           out_pitch_avg
);

  localparam int SW  = $clog2(270 * AVG_WINDOW + 1);
  localparam int DW  = SW + 1;
  localparam int NW  = $clog2(AVG_WINDOW + 1);
  localparam int SLW = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;
  localparam int CW  = $clog2(DW);
  localparam int XW  = tat_pkg::XW;
  localparam int AW  = tat_pkg::AW;

  logic signed [15:0] bias_x_r, bias_y_r, bias_z_r;
  logic signed [16:0] dx_r, dy_r, dz_r;
  logic signed [XW-1:0] adx_s, ady_s, dz_s, ndx_s, x0, y0, cx, m_r;
  logic signed [AW-1:0] ang;
  logic [43:0] prod;
  logic [6:0] roll_r;
  logic [8:0] pitch_r;
  logic signed [AW-1:0] t128;
  logic signed [AW:0] pth, pv;
  logic [6:0] roll_v;

  logic [6:0] rwin [AVG_WINDOW];
  logic [8:0] pwin [AVG_WINDOW];
  logic [6:0] rold_r;
  logic [8:0] pold_r;
  logic [SW-1:0] rsum_r, psum_r;
  logic [SLW-1:0] slot_r;
  logic [NW-1:0] fill_r, n_r;
  logic full;

  logic [DW-1:0] rq_r, pq_r;
  logic [NW:0] rrem_r, prem_r, rsh, psh;
  logic [CW-1:0] dcnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_x_r <= '0;
      bias_y_r <= '0;
      bias_z_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        tat_pkg::REG_BIAS_X: bias_x_r <= cfg_data;
        tat_pkg::REG_BIAS_Y: bias_y_r <= cfg_data;
        tat_pkg::REG_BIAS_Z: bias_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx_r <= 17'(in_accel_x) - 17'(bias_x_r);
      dy_r <= 17'(in_accel_y) - 17'(bias_y_r);
      dz_r <= 17'(in_accel_z) - 17'(bias_z_r);
    end
  end

  always_comb begin
    adx_s = XW'(dx_r < 0 ? -dx_r : dx_r) <<< 8;
    ady_s = XW'(dy_r < 0 ? -dy_r : dy_r) <<< 8;
    dz_s  = XW'(dz_r) <<< 8;
    ndx_s = (-XW'(dx_r)) <<< 8;
    case (cmd.pass)
      2'd0:    begin x0 = adx_s; y0 = dz_s;  end
      2'd1:    begin x0 = m_r;   y0 = ady_s; end
      2'd2:    begin x0 = ady_s; y0 = dz_s;  end
      default: begin x0 = m_r;   y0 = ndx_s; end
    endcase
  end

  tat_cordic u_cordic (
    .clk     (clk),
    .load    (cmd.cord_load),
    .step    (cmd.cord_step),
    .idx     (cmd.idx),
    .x0      (x0),
    .y0      (y0),
    .x_out   (cx),
    .ang_out (ang)
  );

  assign prod = 44'(cx[27:0]) * 44'(tat_pkg::INV_GAIN);

  always_ff @(posedge clk) begin
    if (cmd.mul) m_r <= XW'(prod[43:16]);
  end

  always_comb begin
    t128 = ang + tat_pkg::ANG_GRD;
    if (dy_r == 0)                 roll_v = 7'd0;
    else if (m_r == 0)             roll_v = 7'd90;
    else if (ang < 0)              roll_v = 7'd0;
    else if (ang > tat_pkg::ANG_90) roll_v = 7'd90;
    else                           roll_v = t128[22:16];
    if (dx_r == 0)                 pth = '0;
    else if (m_r == 0)             pth = (dx_r > 0) ? -(AW+1)'(tat_pkg::ANG_90)
                                                    : (AW+1)'(tat_pkg::ANG_90);
    else if (ang < -tat_pkg::ANG_90) pth = -(AW+1)'(tat_pkg::ANG_90);
    else if (ang > tat_pkg::ANG_90)  pth = (AW+1)'(tat_pkg::ANG_90);
    else                           pth = (AW+1)'(ang);
    pv = 26'sd11796480 - pth + 26'sd128;
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      if (cmd.pass == 2'd1) roll_r  <= roll_v;
      else                  pitch_r <= pv[24:16];
    end
  end

  assign full = (fill_r == NW'(AVG_WINDOW));

  always_ff @(posedge clk) begin
    if (cmd.win_rd) begin
      rold_r <= rwin[slot_r];
      pold_r <= pwin[slot_r];
    end
    if (cmd.win_upd) begin
      rwin[slot_r] <= roll_r;
      pwin[slot_r] <= pitch_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsum_r <= '0;
      psum_r <= '0;
      slot_r <= '0;
      fill_r <= '0;
    end else if (cmd.win_upd) begin
      rsum_r <= rsum_r - (full ? SW'(rold_r) : '0) + SW'(roll_r);
      psum_r <= psum_r - (full ? SW'(pold_r) : '0) + SW'(pitch_r);
      slot_r <= (slot_r == SLW'(AVG_WINDOW - 1)) ? '0 : slot_r + 1'b1;
      if (!full) fill_r <= fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.win_upd) n_r <= full ? fill_r : fill_r + 1'b1;
  end

  assign rsh = {rrem_r[NW-1:0], rq_r[DW-1]};
  assign psh = {prem_r[NW-1:0], pq_r[DW-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rq_r   <= DW'(rsum_r) + DW'(n_r >> 1);
      pq_r   <= DW'(psum_r) + DW'(n_r >> 1);
      rrem_r <= '0;
      prem_r <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      if (rsh >= {1'b0, n_r}) begin
        rrem_r <= rsh - {1'b0, n_r};
        rq_r   <= {rq_r[DW-2:0], 1'b1};
      end else begin
        rrem_r <= rsh;
        rq_r   <= {rq_r[DW-2:0], 1'b0};
      end
      if (psh >= {1'b0, n_r}) begin
        prem_r <= psh - {1'b0, n_r};
        pq_r   <= {pq_r[DW-2:0], 1'b1};
      end else begin
        prem_r <= psh;
        pq_r   <= {pq_r[DW-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r + 1'b1;
    end
  end

  assign status.div_done = (dcnt_r == CW'(DW - 1));

  assign out_roll_now  = roll_r;
  assign out_pitch_now = pitch_r;
  assign out_roll_avg  = rq_r[6:0];
  assign out_pitch_avg = pq_r[8:0];

endmodule

>>> rtl/core/tat_ctrl.sv
// ----------------------------------------------------------------------------
// tat_ctrl
// Sequencer: four CORDIC passes, window update, divide, result handshake.
// ----------------------------------------------------------------------------
module tat_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  tat_pkg::status_t   status,
  output tat_pkg::cmd_t      cmd
);

  tat_pkg::state_t state_r, state_nxt;
  logic [1:0] pass_r, pass_nxt;
  logic [tat_pkg::IDX_W-1:0] iter_r, iter_nxt;
  logic out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    iter_nxt      = iter_r;
    out_valid_nxt = out_valid_r;
    case (state_r)
      tat_pkg::ST_IDLE: begin
        if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
        if (in_valid && !out_valid_r) begin
          state_nxt = tat_pkg::ST_CSTART;
          pass_nxt  = 2'd0;
        end
      end
      tat_pkg::ST_CSTART: begin
        state_nxt = tat_pkg::ST_RUN;
        iter_nxt  = '0;
      end
      tat_pkg::ST_RUN: begin
        iter_nxt = iter_r + 1'b1;
        if (iter_r == tat_pkg::IDX_W'(tat_pkg::CORDIC_STEPS - 1)) begin
          state_nxt = tat_pkg::ST_POST;
          iter_nxt  = '0;
        end
      end
      tat_pkg::ST_POST: begin
        if (pass_r == 2'd3) begin
          state_nxt = tat_pkg::ST_WRD;
        end else begin
          state_nxt = tat_pkg::ST_CSTART;
          pass_nxt  = pass_r + 1'b1;
        end
      end
      tat_pkg::ST_WRD:    state_nxt = tat_pkg::ST_SUM;
      tat_pkg::ST_SUM:    state_nxt = tat_pkg::ST_DSTART;
      tat_pkg::ST_DSTART: state_nxt = tat_pkg::ST_DIV;
      tat_pkg::ST_DIV: begin
        if (status.div_done) begin
          state_nxt     = tat_pkg::ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = tat_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.pass      = pass_r;
    cmd.idx       = iter_r;
    in_ready      = 1'b0;
    case (state_r)
      tat_pkg::ST_IDLE: begin
        in_ready = !out_valid_r;
        cmd.load = in_valid && !out_valid_r;
      end
      tat_pkg::ST_CSTART: cmd.cord_load = 1'b1;
      tat_pkg::ST_RUN:    cmd.cord_step = 1'b1;
      tat_pkg::ST_POST: begin
        cmd.mul = !pass_r[0];
        cmd.fin = pass_r[0];
      end
      tat_pkg::ST_WRD:    cmd.win_rd    = 1'b1;
      tat_pkg::ST_SUM:    cmd.win_upd   = 1'b1;
      tat_pkg::ST_DSTART: cmd.div_start = 1'b1;
      tat_pkg::ST_DIV:    cmd.div_step  = 1'b1;
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tat_pkg::ST_IDLE;
      pass_r      <= '0;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken while word pending");
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == tat_pkg::ST_CSTART && pass_r == 2'd0))
    else $error("accept did not start first pass");
  a_iter_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != tat_pkg::ST_RUN) |-> (iter_r == '0))
    else $error("iteration count not cleared");
  a_busy_no_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != tat_pkg::ST_IDLE) |-> !out_valid)
    else $error("result shown while busy");
`endif

endmodule

>>> rtl/core/accel_tilt_angles_averaged_top.sv
// ----------------------------------------------------------------------------
// accel_tilt_angles_averaged_top
// Roll and pitch from a biased 3-axis sample, with moving averages.
//
//   channel | ports                               | handshake
//   input   | in_accel_x/y/z                      | in_valid / in_ready
//   result  | out_roll_now/pitch_now/_avg         | out_valid / out_ready
//   config  | cfg_index, cfg_data                 | cfg_wr_en, no wait
//
// After acceptance a word runs four passes through the shared CORDIC unit,
// which takes one micro-rotation per cycle, then the window read, window
// update and divide before out_valid.
// Reset is synchronous, active low; the window needs no clearing pass.
// A new word is taken only after the previous result has been taken.
// ----------------------------------------------------------------------------
module accel_tilt_angles_averaged_top #(
  parameter int AVG_WINDOW = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [6:0]         out_roll_now,
  output logic [8:0]         out_pitch_now,
  output logic [6:0]         out_roll_avg,
  output logic [8:0]         out_pitch_avg
);

  tat_pkg::cmd_t    cmd;
  tat_pkg::status_t status;

  tat_dp #(.AVG_WINDOW(AVG_WINDOW)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_accel_x    (in_accel_x),
    .in_accel_y    (in_accel_y),
    .in_accel_z    (in_accel_z),
    .out_roll_now  (out_roll_now),
    .out_pitch_now (out_pitch_now),
    .out_roll_avg  (out_roll_avg),
    .out_pitch_avg (out_pitch_avg)
  );

  tat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

endmodule
